// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lgs_pkg.sv =====
// Package for the life generation stencil: defaults, codes and rule constants
package lgs_pkg;

  localparam int unsigned DefMaxWidth   = 1024;
  localparam int unsigned DefMaxHeight  = 1024;
  localparam int unsigned DefGridWidth  = 1024;
  localparam int unsigned DefGridHeight = 1024;
  localparam int unsigned CfgDataW      = 11;
  localparam int unsigned CfgIdxW       = 2;

  // neighbour counts of the B3/S23 rule
  localparam logic [3:0] BirthCount   = 4'd3;
  localparam logic [3:0] SurviveLow   = 4'd2;
  localparam logic [3:0] SurviveHigh  = 4'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_CELL  = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

endpackage

// ===== rtl/lgs_ram.sv =====
// Generic simple dual-port RAM with registered read
module lgs_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/life_generation_stencil_unit.sv =====
// Streaming B3/S23 next-generation stencil with line buffer RAM and 3x3 window
// Output: the result for cell p is registered and shown in the cycle after the transfer of item p+W+1.
// Throughput: one item per cycle while in_stall_o is low; the window, neighbour count and line buffer RAM
// (one write and one look-ahead read per cycle) all run in a single registered pass.
// Reset clears positions, window, result valid and grid size (1024 x 1024, clamped);
// the line buffer RAM is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module life_generation_stencil_unit
  import lgs_pkg::*;
#(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic                alive_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                next_alive_o,
  output logic                row_end_o,
  output logic                frame_end_o
);

  localparam int unsigned WW = $clog2(MaxWidth + 1);
  localparam int unsigned HW = $clog2(MaxHeight + 1);
  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned OH = $clog2(MaxHeight);
  localparam int unsigned RW = $clog2(MaxHeight + 2);
  localparam int unsigned ResetW = (DefGridWidth > MaxWidth) ? MaxWidth : DefGridWidth;
  localparam int unsigned ResetH = (DefGridHeight > MaxHeight) ? MaxHeight : DefGridHeight;

  logic [WW-1:0] w_q, w_d;
  logic [HW-1:0] h_q, h_d;
  logic          cfg_restart;

  logic [CW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [OH-1:0] out_row_q, out_row_d;
  logic [8:0]    win_q, win_d, win_nxt;

  logic          xfer_in, step, primed, res, frame_done;
  logic          cur_cell;
  logic [2:0]    triple;
  logic [1:0]    lb_rdata, lb_line, lb_wdata, byp_data_q;
  logic          byp_q, lb_re;
  logic          in_last_col;
  logic          first_col, last_col, first_row, last_row;
  logic [3:0]    cnt;
  logic          nxt_alive;

  logic          out_valid_q, out_valid_d;
  logic          next_alive_q, row_end_q, frame_end_q;

  // configuration, stored already clamped
  always_comb begin
    w_d = w_q;
    h_d = h_q;
    cfg_restart = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_WIDTH: begin
          cfg_restart = 1'b1;
          if (cfg_wdata_i == '0) begin
            w_d = WW'(1);
          end else if (32'(cfg_wdata_i) > MaxWidth) begin
            w_d = WW'(MaxWidth);
          end else begin
            w_d = WW'(cfg_wdata_i);
          end
        end
        CFG_GRID_HEIGHT: begin
          cfg_restart = 1'b1;
          if (cfg_wdata_i == '0) begin
            h_d = HW'(1);
          end else if (32'(cfg_wdata_i) > MaxHeight) begin
            h_d = HW'(MaxHeight);
          end else begin
            h_d = HW'(cfg_wdata_i);
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q & out_stall_i;
  assign xfer_in    = in_valid_i & ~in_stall_o;

  // a flush at the very start of a frame is dropped
  assign step   = xfer_in &
                  ~((op_e'(op_i) == OP_FLUSH) && (in_row_q == '0) && (in_col_q == '0));
  assign primed = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
  assign res    = step & primed;

  assign cur_cell = (op_e'(op_i) == OP_CELL) && (in_row_q < RW'(h_q)) && alive_i;

  // line buffer: bit 0 row above, bit 1 row two above
  assign lb_line  = byp_q ? byp_data_q : lb_rdata;
  assign triple   = {cur_cell, lb_line[0], lb_line[1]};
  assign lb_wdata = {lb_line[0], cur_cell};
  assign win_nxt  = {win_q[5:0], triple};

  assign in_last_col = (WW'(in_col_q) + WW'(1)) >= w_q;

  assign first_col = (out_col_q == '0);
  assign last_col  = (WW'(out_col_q) + WW'(1)) == w_q;
  assign first_row = (out_row_q == '0);
  assign last_row  = (HW'(out_row_q) + HW'(1)) == h_q;

  always_comb begin
    cnt = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (!(c == 1 && r == 1) && !(c == 0 && last_col) && !(c == 2 && first_col) &&
            !(r == 0 && first_row) && !(r == 2 && last_row)) begin
          cnt = cnt + 4'(win_nxt[c*3+r]);
        end
      end
    end
  end

  assign nxt_alive  = win_nxt[4] ? ((cnt == SurviveLow) || (cnt == SurviveHigh))
                                 : (cnt == BirthCount);
  assign frame_done = res & last_col & last_row;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    win_d     = win_q;
    if (cfg_restart || frame_done) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      win_d     = '0;
    end else if (step) begin
      win_d = win_nxt;
      if (in_last_col) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (res) begin
        if (last_col) begin
          out_col_d = '0;
          out_row_d = out_row_q + OH'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  // look-ahead read of the next column
  assign lb_re = step | cfg_restart;

  lgs_ram #(
    .Width(2),
    .Depth(MaxWidth)
  ) u_line_buf (
    .clk_i  (clk_i),
    .we_i   (step),
    .waddr_i(in_col_q),
    .wdata_i(lb_wdata),
    .re_i   (lb_re),
    .raddr_i(in_col_d),
    .rdata_o(lb_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (lb_re) begin
      byp_q <= step && (in_col_d == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (lb_re) begin
      byp_data_q <= lb_wdata;
    end
  end

  assign out_valid_d = res | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= WW'(ResetW);
      h_q         <= HW'(ResetH);
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      w_q         <= w_d;
      h_q         <= h_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      win_q       <= win_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res) begin
      next_alive_q <= nxt_alive;
      row_end_q    <= last_col;
      frame_end_q  <= last_col & last_row;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_alive_o = next_alive_q;
  assign row_end_o    = row_end_q;
  assign frame_end_o  = frame_end_q;

  `ASSERT_ALWAYS(a_in_col_range, WW'(in_col_q) < w_q, "input column beyond grid width")
  `ASSERT_ALWAYS(a_out_col_range, WW'(out_col_q) < w_q, "output column beyond grid width")
  `ASSERT_ALWAYS(a_in_row_range, in_row_q <= RW'(h_q) + RW'(1), "input row beyond drain")
  `ASSERT_IMPLIES(a_frame_row_end, out_valid_o && frame_end_o, row_end_o,
                  "frame end without row end")
  `ASSERT_NEXT(a_frame_restart, frame_done,
               in_col_q == '0 && in_row_q == '0 && out_row_q == '0 && win_q == '0,
               "stream not restarted after frame end")

endmodule
